// ----- hdl/mbrot_pkg.sv -----
package mbrot_pkg;

    // Field and datapath widths
    localparam int FRAC_BITS  = 28;
    localparam int FX_W       = 32;                 // Q4.28 signed
    localparam int PROD_W     = 2 * FX_W;           // full signed product
    localparam int SQ_W       = PROD_W - FRAC_BITS; // product after the binary point shift
    localparam int SUM_W      = SQ_W + 1;           // headroom for the z update sums
    localparam int PIX_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int ITER_W     = 10;
    localparam int CNT_W      = ITER_W + 1;         // count may pass the limit by one
    localparam int COL_W      = 8;
    localparam int NUM_W      = PIX_W + 2 + FRAC_BITS; // (4 * pixel) << FRAC_BITS
    localparam int REM_W      = SIZE_W - 1;         // remainder stays below the divisor
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd3;

    // Constants
    localparam logic [SIZE_W-1:0]        MAX_SIZE  = 13'd4096;
    localparam logic [COL_W-1:0]         LEVEL_MAX = 8'd255;
    localparam logic signed [FX_W-1:0]   FX_MAX    = 32'sh7fff_ffff;
    localparam logic signed [FX_W-1:0]   FX_MIN    = 32'sh8000_0000;
    localparam logic [FX_W-1:0]          FX_TWO    = 32'h2000_0000;
    // quotient at which q - 2.0 no longer fits Q4.28
    localparam logic [NUM_W-1:0]         Q_SAT     = 42'h000_a000_0000;
    // |z|^2 escape threshold, 4.0
    localparam logic [SUM_W-1:0]         ESC_LIM   = 37'h0_4000_0000;
    // bias that turns an arithmetic shift of a negative product into truncation toward zero
    localparam logic [PROD_W-1:0]        TRUNC_FIX = 64'h0000_0000_0fff_ffff;

    typedef logic signed [FX_W-1:0] t_fx;

    // Word handed from one divider cell to the next
    typedef struct packed {
        logic             valid;
        logic [REM_W-1:0] rem;
    } t_div_link;

    // Clamp a wide sum onto the Q4.28 range
    function automatic t_fx fx_sat(input logic signed [SUM_W-1:0] v);
        t_fx r;
        if (!v[SUM_W-1] && (v[SUM_W-2:FX_W-1] != '0)) begin
            r = FX_MAX;
        end else if (v[SUM_W-1] && (v[SUM_W-2:FX_W-1] != '1)) begin
            r = FX_MIN;
        end else begin
            r = $signed(v[FX_W-1:0]);
        end
        return r;
    endfunction

endpackage

// ----- hdl/mbrot_div_cell.sv -----
module mbrot_div_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbrot_pkg::t_div_link           i_link,
    input  logic                           i_numer_bit,
    input  logic [mbrot_pkg::SIZE_W-1:0]   i_divisor,
    output mbrot_pkg::t_div_link           o_link,
    output logic                           o_qbit
);

    logic                          r_valid;
    logic [mbrot_pkg::REM_W-1:0]   r_rem;
    logic                          r_qbit;
    logic [mbrot_pkg::SIZE_W-1:0]  w_trial;
    logic [mbrot_pkg::SIZE_W-1:0]  w_diff;
    logic                          w_ge;
    logic [mbrot_pkg::REM_W-1:0]   n_rem;

    // One restoring step: bring down a numerator bit, subtract if it fits
    assign w_trial = {i_link.rem, i_numer_bit};
    assign w_ge    = (w_trial >= i_divisor);
    assign w_diff  = w_trial - i_divisor;
    assign n_rem   = w_ge ? w_diff[mbrot_pkg::REM_W-1:0] : w_trial[mbrot_pkg::REM_W-1:0];

    // Wavefront token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_link.valid;
        end
    end

    // Remainder moves on, quotient bit stays here until the next pass
    always_ff @(posedge i_clk) begin
        if (i_link.valid) begin
            r_rem  <= n_rem;
            r_qbit <= w_ge;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.rem   = r_rem;
    assign o_qbit       = r_qbit;

endmodule

// ----- hdl/mbrot_div_chain.sv -----
module mbrot_div_chain (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mbrot_pkg::NUM_W-1:0]    i_numer,
    input  logic [mbrot_pkg::SIZE_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [mbrot_pkg::NUM_W-1:0]    o_quot
);

    logic                          r_go;
    logic [mbrot_pkg::NUM_W-1:0]   r_numer;
    logic [mbrot_pkg::SIZE_W-1:0]  r_divisor;
    mbrot_pkg::t_div_link          w_link [0:mbrot_pkg::NUM_W];
    wire  [mbrot_pkg::NUM_W-1:0]   w_qbit;

    // Launch token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_start;
        end
    end

    // Operands held for the whole pass
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_numer   <= i_numer;
            r_divisor <= i_divisor;
        end
    end

    assign w_link[0] = {r_go, {mbrot_pkg::REM_W{1'b0}}};

    // Cell k works on numerator bit NUM_W-1-k, most significant first
    for (genvar k = 0; k < mbrot_pkg::NUM_W; k++) begin : g_cell
        mbrot_div_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_link      (w_link[k]),
            .i_numer_bit (r_numer[mbrot_pkg::NUM_W-1-k]),
            .i_divisor   (r_divisor),
            .o_link      (w_link[k+1]),
            .o_qbit      (w_qbit[mbrot_pkg::NUM_W-1-k])
        );
    end

    assign o_done = w_link[mbrot_pkg::NUM_W].valid;
    assign o_quot = w_qbit;

endmodule

// ----- hdl/mbrot_core.sv -----
module mbrot_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  mbrot_pkg::t_fx                 i_cr,
    input  mbrot_pkg::t_fx                 i_ci,
    input  logic [mbrot_pkg::ITER_W-1:0]   i_count0,
    input  logic [mbrot_pkg::ITER_W-1:0]   i_lim,
    output logic                           o_done,
    output logic [mbrot_pkg::CNT_W-1:0]    o_count
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_MUL  = 2'd1;
    localparam logic [1:0] C_SQ   = 2'd2;
    localparam logic [1:0] C_UPD  = 2'd3;

    logic [1:0]                          r_state;
    logic [1:0]                          n_state;
    logic                                r_done;
    logic                                n_done;
    mbrot_pkg::t_fx                      r_zr;
    mbrot_pkg::t_fx                      r_zi;
    logic [mbrot_pkg::CNT_W-1:0]         r_count;
    logic signed [mbrot_pkg::PROD_W-1:0] r_p_rr;
    logic signed [mbrot_pkg::PROD_W-1:0] r_p_ii;
    logic signed [mbrot_pkg::PROD_W-1:0] r_p_ri;
    logic signed [mbrot_pkg::SUM_W-1:0]  r_diff;
    logic signed [mbrot_pkg::SQ_W-1:0]   r_zri;

    logic signed [mbrot_pkg::PROD_W-1:0] w_p_rr;
    logic signed [mbrot_pkg::PROD_W-1:0] w_p_ii;
    logic signed [mbrot_pkg::PROD_W-1:0] w_p_ri;
    logic [mbrot_pkg::SQ_W-1:0]          w_zr2;
    logic [mbrot_pkg::SQ_W-1:0]          w_zi2;
    logic [mbrot_pkg::SUM_W-1:0]         w_mag;
    logic                                w_esc;
    logic signed [mbrot_pkg::SUM_W-1:0]  w_diff;
    logic [mbrot_pkg::PROD_W-1:0]        w_ri_adj;
    logic signed [mbrot_pkg::SUM_W-1:0]  w_zr_sum;
    logic signed [mbrot_pkg::SUM_W-1:0]  w_zi_sum;
    logic                                w_over;

    // Stage 1: the three products of the current z
    assign w_p_rr = r_zr * r_zr;
    assign w_p_ii = r_zi * r_zi;
    assign w_p_ri = r_zr * r_zi;

    // Stage 2: drop the fraction bits, escape test, real part difference
    // squares are never negative, so a plain shift is already truncation
    assign w_zr2    = r_p_rr[mbrot_pkg::PROD_W-1:mbrot_pkg::FRAC_BITS];
    assign w_zi2    = r_p_ii[mbrot_pkg::PROD_W-1:mbrot_pkg::FRAC_BITS];
    assign w_mag    = {1'b0, w_zr2} + {1'b0, w_zi2};
    assign w_esc    = (w_mag >= mbrot_pkg::ESC_LIM);
    assign w_diff   = $signed({1'b0, w_zr2}) - $signed({1'b0, w_zi2});
    // cross product truncates toward zero
    assign w_ri_adj = r_p_ri + (r_p_ri[mbrot_pkg::PROD_W-1] ? mbrot_pkg::TRUNC_FIX
                                                              : {mbrot_pkg::PROD_W{1'b0}});

    // Stage 3: add c and clamp
    assign w_zr_sum = r_diff + mbrot_pkg::SUM_W'(i_cr);
    assign w_zi_sum = $signed({r_zri, 1'b0}) + mbrot_pkg::SUM_W'(i_ci);

    assign w_over = (r_count > mbrot_pkg::CNT_W'(i_lim));

    // Iteration sequencer
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_state = C_MUL;
                end
            end
            C_MUL: begin
                if (w_over) begin
                    n_state = C_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = C_SQ;
                end
            end
            C_SQ: begin
                if (w_esc) begin
                    n_state = C_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = C_UPD;
                end
            end
            C_UPD: begin
                n_state = C_MUL;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == C_MUL) begin
            r_p_rr <= w_p_rr;
            r_p_ii <= w_p_ii;
            r_p_ri <= w_p_ri;
        end
        if (r_state == C_SQ) begin
            r_diff <= w_diff;
            r_zri  <= $signed(w_ri_adj[mbrot_pkg::PROD_W-1:mbrot_pkg::FRAC_BITS]);
        end
        if ((r_state == C_IDLE) && i_start) begin
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= mbrot_pkg::CNT_W'(i_count0);
        end else if (r_state == C_UPD) begin
            r_zr    <= mbrot_pkg::fx_sat(w_zr_sum);
            r_zi    <= mbrot_pkg::fx_sat(w_zi_sum);
            r_count <= r_count + 1'b1;
        end
    end

    assign o_done  = r_done;
    assign o_count = r_count;

endmodule

// ----- hdl/mandelbrot_escape_time_pixel_unit.sv -----
// Escape-time evaluator for one Mandelbrot pixel.
// Input channel: i_valid / o_stall with i_pixel_x, i_pixel_y; a word is taken
// when i_valid is high and o_stall is low. Output channel: o_valid / i_stall
// with o_level, o_red, o_green, o_blue; one result word per input word, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Write only while no pixel is in flight.
// One pixel is worked on at a time. Between the accepting edge and o_valid the
// pixel goes through the two coordinate divisions, the z updates and, for a
// pixel that escapes, the level division (none when the limit is reached). Each
// z update runs through three steps on the multipliers (product, shift and escape
// test, add and clamp); each division runs through the 42-cell restoring divider
// chain. The next pixel is taken the cycle after the previous one reaches the
// output register, and the input stalls until then; a stalled result waits in
// that register. If the receiver still stalls when the next result is ready,
// that pixel waits until the register is free.
// Synchronous active-low reset empties the block and restores the register
// defaults: min 0, max 255, width 800, height 800.
module mandelbrot_escape_time_pixel_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mbrot_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic [mbrot_pkg::PIX_W-1:0]       i_pixel_y,
    // result output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [mbrot_pkg::COL_W-1:0]       o_level,
    output logic [mbrot_pkg::COL_W-1:0]       o_red,
    output logic [mbrot_pkg::COL_W-1:0]       o_green,
    output logic [mbrot_pkg::COL_W-1:0]       o_blue,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbrot_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbrot_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVX = 3'd1;
    localparam logic [2:0] S_DIVY = 3'd2;
    localparam logic [2:0] S_ITER = 3'd3;
    localparam logic [2:0] S_DIVL = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int SCALED_W = mbrot_pkg::ITER_W + mbrot_pkg::COL_W;

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;
    logic                              r_div_start;
    logic                              n_div_start;
    logic                              r_core_start;
    logic                              n_core_start;

    logic [mbrot_pkg::ITER_W-1:0]      r_min_iter;
    logic [mbrot_pkg::ITER_W-1:0]      r_max_iter;
    logic [mbrot_pkg::SIZE_W-1:0]      r_width;
    logic [mbrot_pkg::SIZE_W-1:0]      r_height;

    logic [mbrot_pkg::PIX_W-1:0]       r_px;
    logic [mbrot_pkg::PIX_W-1:0]       r_py;
    mbrot_pkg::t_fx                    r_cr;
    mbrot_pkg::t_fx                    r_ci;
    logic [mbrot_pkg::CNT_W-1:0]       r_count;
    logic [mbrot_pkg::COL_W-1:0]       r_level;

    logic                              r_out_valid;
    logic [mbrot_pkg::COL_W-1:0]       r_out_level;
    logic [mbrot_pkg::COL_W-1:0]       r_out_red;
    logic [mbrot_pkg::COL_W-1:0]       r_out_green;
    logic [mbrot_pkg::COL_W-1:0]       r_out_blue;

    logic [mbrot_pkg::SIZE_W-1:0]      w_width_eff;
    logic [mbrot_pkg::SIZE_W-1:0]      w_height_eff;
    logic [mbrot_pkg::ITER_W-1:0]      w_lim;
    logic [SCALED_W-1:0]               w_scaled;
    logic [mbrot_pkg::NUM_W-1:0]       w_div_numer;
    logic [mbrot_pkg::SIZE_W-1:0]      w_div_divisor;
    logic                              w_div_done;
    logic [mbrot_pkg::NUM_W-1:0]       w_quot;
    mbrot_pkg::t_fx                    w_coord;
    logic                              w_core_done;
    logic [mbrot_pkg::CNT_W-1:0]       w_core_count;
    logic                              w_in_take;
    logic                              w_out_load;
    logic                              w_escaped;

    // Register port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_iter <= 10'd0;
            r_max_iter <= 10'd255;
            r_width    <= 13'd800;
            r_height   <= 13'd800;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mbrot_pkg::CFG_MIN_ITER: r_min_iter <= i_cfg_data[mbrot_pkg::ITER_W-1:0];
                mbrot_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data[mbrot_pkg::ITER_W-1:0];
                mbrot_pkg::CFG_WIDTH:    r_width    <= i_cfg_data[mbrot_pkg::SIZE_W-1:0];
                mbrot_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data[mbrot_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes and limit: zero reads as one, sizes capped
    always_comb begin
        if (r_width == '0) begin
            w_width_eff = mbrot_pkg::SIZE_W'(1);
        end else if (r_width > mbrot_pkg::MAX_SIZE) begin
            w_width_eff = mbrot_pkg::MAX_SIZE;
        end else begin
            w_width_eff = r_width;
        end
        if (r_height == '0) begin
            w_height_eff = mbrot_pkg::SIZE_W'(1);
        end else if (r_height > mbrot_pkg::MAX_SIZE) begin
            w_height_eff = mbrot_pkg::MAX_SIZE;
        end else begin
            w_height_eff = r_height;
        end
        w_lim = (r_max_iter == '0) ? mbrot_pkg::ITER_W'(1) : r_max_iter;
    end

    // 255 * count, count being below the limit here
    assign w_scaled = {r_count[mbrot_pkg::ITER_W-1:0], {mbrot_pkg::COL_W{1'b0}}}
                    - SCALED_W'(r_count[mbrot_pkg::ITER_W-1:0]);

    // Divider operand select
    always_comb begin
        case (r_state)
            S_DIVX: begin
                w_div_numer   = {r_px, 2'b00, {mbrot_pkg::FRAC_BITS{1'b0}}};
                w_div_divisor = w_width_eff;
            end
            S_DIVY: begin
                w_div_numer   = {r_py, 2'b00, {mbrot_pkg::FRAC_BITS{1'b0}}};
                w_div_divisor = w_height_eff;
            end
            default: begin
                w_div_numer   = mbrot_pkg::NUM_W'(w_scaled);
                w_div_divisor = mbrot_pkg::SIZE_W'(w_lim);
            end
        endcase
    end

    mbrot_div_chain u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_numer   (w_div_numer),
        .i_divisor (w_div_divisor),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // Coordinate: quotient minus 2.0, clamped at the top of the range
    assign w_coord = (w_quot >= mbrot_pkg::Q_SAT) ? mbrot_pkg::FX_MAX
                   : $signed(w_quot[mbrot_pkg::FX_W-1:0] - mbrot_pkg::FX_TWO);

    mbrot_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_core_start),
        .i_cr     (r_cr),
        .i_ci     (r_ci),
        .i_count0 (r_min_iter),
        .i_lim    (w_lim),
        .o_done   (w_core_done),
        .o_count  (w_core_count)
    );

    assign w_escaped  = (w_core_count < mbrot_pkg::CNT_W'(w_lim));
    assign w_in_take  = i_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    // Pixel sequencer
    always_comb begin
        n_state      = r_state;
        n_div_start  = 1'b0;
        n_core_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state     = S_DIVX;
                    n_div_start = 1'b1;
                end
            end
            S_DIVX: begin
                if (w_div_done) begin
                    n_state     = S_DIVY;
                    n_div_start = 1'b1;
                end
            end
            S_DIVY: begin
                if (w_div_done) begin
                    n_state      = S_ITER;
                    n_core_start = 1'b1;
                end
            end
            S_ITER: begin
                if (w_core_done) begin
                    if (w_escaped) begin
                        n_state     = S_DIVL;
                        n_div_start = 1'b1;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_DIVL: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_div_start  <= 1'b0;
            r_core_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_div_start  <= n_div_start;
            r_core_start <= n_core_start;
        end
    end

    // Per-pixel working values
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if ((r_state == S_DIVX) && w_div_done) begin
            r_cr <= w_coord;
        end
        if ((r_state == S_DIVY) && w_div_done) begin
            r_ci <= w_coord;
        end
        if ((r_state == S_ITER) && w_core_done) begin
            r_count <= w_core_count;
            r_level <= '0;
        end
        if ((r_state == S_DIVL) && w_div_done) begin
            r_level <= w_quot[mbrot_pkg::COL_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_level <= r_level;
            if (r_level == '0) begin
                r_out_red   <= '0;
                r_out_green <= '0;
                r_out_blue  <= '0;
            end else begin
                r_out_red   <= mbrot_pkg::LEVEL_MAX;
                r_out_green <= mbrot_pkg::LEVEL_MAX - r_level;
                r_out_blue  <= mbrot_pkg::LEVEL_MAX - r_level;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_level = r_out_level;
    assign o_red   = r_out_red;
    assign o_green = r_out_green;
    assign o_blue  = r_out_blue;

endmodule
